// ===== src/rar_pkg.sv =====
// ----------------------------------------------------------------------------
// rar_pkg: shared definitions for the rational arithmetic reducer
// Operation codes, output widths and the control word that travels with
// each request through the pipeline.
// ----------------------------------------------------------------------------
package rar_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int REQ_W             = 2;
    localparam int NUM_OUT_W         = 33;
    localparam int DEN_OUT_W         = 32;
    localparam int OUT_TDATA_W       = ((NUM_OUT_W + DEN_OUT_W + 7) / 8) * 8;

    localparam logic [REQ_W-1:0] OP_ADD = 2'd0;
    localparam logic [REQ_W-1:0] OP_SUB = 2'd1;
    localparam logic [REQ_W-1:0] OP_MUL = 2'd2;
    localparam logic [REQ_W-1:0] OP_DIV = 2'd3;

    typedef struct packed {
        logic valid;
        logic err;
        logic neg_num;
        logic neg_den;
    } ctl_t;

endpackage

// ===== src/rar_front.sv =====
// ----------------------------------------------------------------------------
// rar_front: cross multiplication and combination
// Two register stages: the three products, then the signed numerator and
// denominator split into sign and magnitude (magnitudes 0 and 1 on an error).
// ----------------------------------------------------------------------------
module rar_front
    import rar_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [REQ_W-1:0]             op,
    input  logic signed [OPERAND_WIDTH-1:0] num_a,
    input  logic signed [OPERAND_WIDTH-1:0] den_a,
    input  logic signed [OPERAND_WIDTH-1:0] num_b,
    input  logic signed [OPERAND_WIDTH-1:0] den_b,
    output ctl_t                         ctl,
    output logic [2*OPERAND_WIDTH-1:0]   num_mag,
    output logic [2*OPERAND_WIDTH-1:0]   den_mag
);

    localparam int W  = OPERAND_WIDTH;
    localparam int MW = 2 * W;

    logic                  valid1_reg;
    logic                  err1_reg;
    logic [REQ_W-1:0]      op1_reg;
    logic signed [MW-1:0]  pa_reg, pa_next;
    logic signed [MW-1:0]  pb_reg, pb_next;
    logic signed [MW-1:0]  pc_reg, pc_next;
    logic                  err_next;

    ctl_t                  ctl_reg, ctl_next;
    logic [MW-1:0]         num_mag_reg, num_mag_next;
    logic [MW-1:0]         den_mag_reg, den_mag_next;
    logic signed [MW:0]    rn;
    logic signed [MW:0]    rd;

    always_comb
    begin
        pa_next  = num_a * ((op == OP_MUL) ? num_b : den_b);
        pb_next  = num_b * den_a;
        pc_next  = den_a * den_b;
        err_next = (den_a == '0) || (den_b == '0) || ((op == OP_DIV) && (num_b == '0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
        end
        else if (en)
        begin
            valid1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            err1_reg <= err_next;
            op1_reg  <= op;
            pa_reg   <= pa_next;
            pb_reg   <= pb_next;
            pc_reg   <= pc_next;
        end
    end

    always_comb
    begin
        case (op1_reg)
            OP_ADD:  rn = (MW+1)'(pa_reg) + (MW+1)'(pb_reg);
            OP_SUB:  rn = (MW+1)'(pa_reg) - (MW+1)'(pb_reg);
            default: rn = (MW+1)'(pa_reg);
        endcase
        rd = (op1_reg == OP_DIV) ? (MW+1)'(pb_reg) : (MW+1)'(pc_reg);
        ctl_next.valid   = valid1_reg;
        ctl_next.err     = err1_reg;
        ctl_next.neg_num = rn[MW];
        ctl_next.neg_den = rd[MW];
        num_mag_next     = rn[MW] ? MW'(-rn) : MW'(rn);
        den_mag_next     = rd[MW] ? MW'(-rd) : MW'(rd);
        if (err1_reg)
        begin
            num_mag_next = '0;
            den_mag_next = MW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_mag_reg <= num_mag_next;
            den_mag_reg <= den_mag_next;
        end
    end

    assign ctl     = ctl_reg;
    assign num_mag = num_mag_reg;
    assign den_mag = den_mag_reg;

endmodule

// ===== src/rar_gcd_stage.sv =====
// ----------------------------------------------------------------------------
// rar_gcd_stage: one step of the binary gcd
// Halves, or subtracts and halves, the working pair once and counts shared
// factors of two; the two magnitudes to be reduced ride along unchanged.
// ----------------------------------------------------------------------------
module rar_gcd_stage
    import rar_pkg::*;
#(
    parameter int MW = 2 * OPERAND_WIDTH_DEF,
    parameter int KW = $clog2(MW + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  ctl_t          ctl_in,
    input  logic [MW-1:0] a_in,
    input  logic [MW-1:0] b_in,
    input  logic [KW-1:0] k_in,
    input  logic [MW-1:0] nm_in,
    input  logic [MW-1:0] dm_in,
    output ctl_t          ctl_out,
    output logic [MW-1:0] a_out,
    output logic [MW-1:0] b_out,
    output logic [KW-1:0] k_out,
    output logic [MW-1:0] nm_out,
    output logic [MW-1:0] dm_out
);

    ctl_t          ctl_reg;
    logic [MW-1:0] a_reg, a_next;
    logic [MW-1:0] b_reg, b_next;
    logic [KW-1:0] k_reg, k_next;
    logic [MW-1:0] nm_reg;
    logic [MW-1:0] dm_reg;

    always_comb
    begin
        a_next = a_in;
        b_next = b_in;
        k_next = k_in;
        if ((a_in == '0) || (b_in == '0))
        begin
            a_next = a_in;
        end
        else if (!a_in[0] && !b_in[0])
        begin
            a_next = a_in >> 1;
            b_next = b_in >> 1;
            k_next = k_in + KW'(1);
        end
        else if (!a_in[0])
        begin
            a_next = a_in >> 1;
        end
        else if (!b_in[0])
        begin
            b_next = b_in >> 1;
        end
        else if (a_in >= b_in)
        begin
            a_next = (a_in - b_in) >> 1;
        end
        else
        begin
            b_next = (b_in - a_in) >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg  <= a_next;
            b_reg  <= b_next;
            k_reg  <= k_next;
            nm_reg <= nm_in;
            dm_reg <= dm_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign a_out   = a_reg;
    assign b_out   = b_reg;
    assign k_out   = k_reg;
    assign nm_out  = nm_reg;
    assign dm_out  = dm_reg;

endmodule

// ===== src/rar_div_stage.sv =====
// ----------------------------------------------------------------------------
// rar_div_stage: one restoring division step for both lanes
// Develops one quotient bit of the numerator and of the denominator
// magnitude, each divided by the gcd.
// ----------------------------------------------------------------------------
module rar_div_stage
    import rar_pkg::*;
#(
    parameter int MW = 2 * OPERAND_WIDTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  ctl_t          ctl_in,
    input  logic [MW-1:0] g_in,
    input  logic [MW:0]   rem_n_in,
    input  logic [MW-1:0] dq_n_in,
    input  logic [MW:0]   rem_d_in,
    input  logic [MW-1:0] dq_d_in,
    output ctl_t          ctl_out,
    output logic [MW-1:0] g_out,
    output logic [MW:0]   rem_n_out,
    output logic [MW-1:0] dq_n_out,
    output logic [MW:0]   rem_d_out,
    output logic [MW-1:0] dq_d_out
);

    ctl_t          ctl_reg;
    logic [MW-1:0] g_reg;
    logic [MW:0]   rem_n_reg, rem_n_next;
    logic [MW-1:0] dq_n_reg, dq_n_next;
    logic [MW:0]   rem_d_reg, rem_d_next;
    logic [MW-1:0] dq_d_reg, dq_d_next;
    logic [MW:0]   g_ext;

    always_comb
    begin
        g_ext      = {1'b0, g_in};
        rem_n_next = {rem_n_in[MW-1:0], dq_n_in[MW-1]};
        dq_n_next  = {dq_n_in[MW-2:0], 1'b0};
        if (rem_n_next >= g_ext)
        begin
            rem_n_next   = rem_n_next - g_ext;
            dq_n_next[0] = 1'b1;
        end
        rem_d_next = {rem_d_in[MW-1:0], dq_d_in[MW-1]};
        dq_d_next  = {dq_d_in[MW-2:0], 1'b0};
        if (rem_d_next >= g_ext)
        begin
            rem_d_next   = rem_d_next - g_ext;
            dq_d_next[0] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_reg     <= g_in;
            rem_n_reg <= rem_n_next;
            dq_n_reg  <= dq_n_next;
            rem_d_reg <= rem_d_next;
            dq_d_reg  <= dq_d_next;
        end
    end

    assign ctl_out   = ctl_reg;
    assign g_out     = g_reg;
    assign rem_n_out = rem_n_reg;
    assign dq_n_out  = dq_n_reg;
    assign rem_d_out = rem_d_reg;
    assign dq_d_out  = dq_d_reg;

endmodule

// ===== src/rational_arith_reduce.sv =====
// ----------------------------------------------------------------------------
// rational_arith_reduce: fraction add, subtract, multiply and divide
// Forms the cross products of two signed fractions and reduces the result
// by the gcd of its magnitudes, keeping the computed signs.
// ----------------------------------------------------------------------------
// Channel | Dir | Contents
// s_*     | in  | tuser: req_type; tdata: num_a, den_a, num_b, den_b
// m_*     | out | tuser: error_flag; tdata: result_num, result_den
//
// One request enters per cycle while the pipeline advances; it passes the front
// stages, 4*W binary gcd steps and 2*W division steps (W = OPERAND_WIDTH).
// The whole pipeline advances together whenever the output register is free
// or being taken; s_tready shows that condition.
// Reset clears all valid bits; the data path has no reset.
// ----------------------------------------------------------------------------
module rational_arith_reduce
    import rar_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // num_a, den_a, num_b, den_b from bit 0 up, zero padded.
    input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]      s_tdata,
    // req_type.
    input  logic [REQ_W-1:0]                          s_tuser,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // result_num, result_den from bit 0 up, zero padded.
    output logic [OUT_TDATA_W-1:0]                    m_tdata,
    // error_flag.
    output logic                                      m_tuser
);

    localparam int W  = OPERAND_WIDTH;
    localparam int MW = 2 * W;
    localparam int KW = $clog2(MW + 1);
    localparam int GS = 2 * MW;

    logic          advance;

    ctl_t          gc [0:GS];
    logic [MW-1:0] ga [0:GS];
    logic [MW-1:0] gb [0:GS];
    logic [KW-1:0] gk [0:GS];
    logic [MW-1:0] gn [0:GS];
    logic [MW-1:0] gd [0:GS];

    ctl_t          dc  [0:MW];
    logic [MW-1:0] dg  [0:MW];
    logic [MW:0]   drn [0:MW];
    logic [MW-1:0] dqn [0:MW];
    logic [MW:0]   drd [0:MW];
    logic [MW-1:0] dqd [0:MW];

    logic                  valid_reg;
    logic [OUT_TDATA_W-1:0] tdata_reg, tdata_next;
    logic                  err_reg;
    logic signed [MW:0]    sn;
    logic signed [MW:0]    sd;
    logic [NUM_OUT_W-1:0]  rnum;
    logic [DEN_OUT_W-1:0]  rden;

    assign advance  = !valid_reg || m_tready;
    assign s_tready = advance;

    rar_front #(.OPERAND_WIDTH(W)) u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .in_valid (s_tvalid),
        .op       (s_tuser),
        .num_a    (s_tdata[W-1:0]),
        .den_a    (s_tdata[2*W-1:W]),
        .num_b    (s_tdata[3*W-1:2*W]),
        .den_b    (s_tdata[4*W-1:3*W]),
        .ctl      (gc[0]),
        .num_mag  (gn[0]),
        .den_mag  (gd[0])
    );

    assign ga[0] = gn[0];
    assign gb[0] = gd[0];
    assign gk[0] = '0;

    for (genvar i = 0; i < GS; i++)
    begin : g_gcd
        rar_gcd_stage #(.MW(MW), .KW(KW)) u_gcd
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (advance),
            .ctl_in  (gc[i]),
            .a_in    (ga[i]),
            .b_in    (gb[i]),
            .k_in    (gk[i]),
            .nm_in   (gn[i]),
            .dm_in   (gd[i]),
            .ctl_out (gc[i+1]),
            .a_out   (ga[i+1]),
            .b_out   (gb[i+1]),
            .k_out   (gk[i+1]),
            .nm_out  (gn[i+1]),
            .dm_out  (gd[i+1])
        );
    end

    assign dc[0]  = gc[GS];
    assign dg[0]  = (ga[GS] | gb[GS]) << gk[GS];
    assign drn[0] = '0;
    assign dqn[0] = gn[GS];
    assign drd[0] = '0;
    assign dqd[0] = gd[GS];

    for (genvar j = 0; j < MW; j++)
    begin : g_div
        rar_div_stage #(.MW(MW)) u_div
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .ctl_in    (dc[j]),
            .g_in      (dg[j]),
            .rem_n_in  (drn[j]),
            .dq_n_in   (dqn[j]),
            .rem_d_in  (drd[j]),
            .dq_d_in   (dqd[j]),
            .ctl_out   (dc[j+1]),
            .g_out     (dg[j+1]),
            .rem_n_out (drn[j+1]),
            .dq_n_out  (dqn[j+1]),
            .rem_d_out (drd[j+1]),
            .dq_d_out  (dqd[j+1])
        );
    end

    always_comb
    begin
        sn = dc[MW].neg_num ? -$signed({1'b0, dqn[MW]}) : $signed({1'b0, dqn[MW]});
        sd = dc[MW].neg_den ? -$signed({1'b0, dqd[MW]}) : $signed({1'b0, dqd[MW]});
        rnum = NUM_OUT_W'(sn);
        rden = DEN_OUT_W'(sd);
        if (dc[MW].err)
        begin
            rnum = '0;
            rden = '0;
        end
        tdata_next = OUT_TDATA_W'({rden, rnum});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= dc[MW].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tdata_reg <= tdata_next;
            err_reg   <= dc[MW].err;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = err_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("error result is not 0/0");

    a_front_den: assert property (@(posedge clk) disable iff (!rst_n)
        gc[0].valid && !gc[0].err |-> gd[0] != '0)
        else $error("zero denominator without error");

    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        gc[GS].valid && !gc[GS].err |-> (ga[GS] == '0 || gb[GS] == '0) && dg[0] != '0)
        else $error("gcd not finished or zero");

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for the rational arithmetic reducer
// Drives fraction requests with random gaps and random output back-pressure,
// predicts each reduced fraction and checks every result in request order.
// ----------------------------------------------------------------------------
module tb_top;
    import rar_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = OPERAND_WIDTH_DEF;
    localparam int IN_W = ((4*W+7)/8)*8;
    localparam int LAT = 2 + 6*W + 1;

    typedef struct packed {
        logic [NUM_OUT_W-1:0] rnum;
        logic [DEN_OUT_W-1:0] rden;
        logic                 err;
    } frac_t;

    int fail_count = 0;

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    class frac_scoreboard;
        frac_t pending[$];

        function automatic longint unsigned mag(input longint v);
            return (v < 0) ? -v : v;
        endfunction

        function automatic longint unsigned gcd(input longint unsigned a,
                                                input longint unsigned b);
            longint unsigned t;
            while (b != 0) begin
                t = a % b;
                a = b;
                b = t;
            end
            return a;
        endfunction

        function void note_request(input logic [REQ_W-1:0] op,
                                   input logic signed [W-1:0] na, da, nb, db);
            frac_t e;
            longint n, d, a1, a2, b1, b2;
            longint unsigned g;
            a1 = na; a2 = da; b1 = nb; b2 = db;
            if (da == 0 || db == 0 || (op == OP_DIV && nb == 0)) begin
                e = '{rnum: '0, rden: '0, err: 1'b1};
            end
            else begin
                case (op)
                    OP_ADD: begin n = a1*b2 + b1*a2; d = a2*b2; end
                    OP_SUB: begin n = a1*b2 - b1*a2; d = a2*b2; end
                    OP_MUL: begin n = a1*b1; d = a2*b2; end
                    default: begin n = a1*b2; d = b1*a2; end
                endcase
                g = gcd(mag(n), mag(d));
                if (g > 1) begin
                    n = n / longint'(g);
                    d = d / longint'(g);
                end
                e.rnum = n[NUM_OUT_W-1:0];
                e.rden = d[DEN_OUT_W-1:0];
                e.err  = (d == 0);
            end
            pending.push_back(e);
        endfunction

        task check_result(input frac_t got);
            frac_t e;
            if (pending.size() == 0) begin
                report("result with no request outstanding");
                return;
            end
            e = pending.pop_front();
            if (got.rnum !== e.rnum)
                report($sformatf("result_num %h, want %h", got.rnum, e.rnum));
            if (got.rden !== e.rden)
                report($sformatf("result_den %h, want %h", got.rden, e.rden));
            if (got.err !== e.err)
                report($sformatf("error_flag %b, want %b", got.err, e.err));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic [REQ_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic m_tuser;

    frac_scoreboard sb = new();
    bit calm = 1'b0;
    bit hold_off = 1'b0;

    always #5 clk = ~clk;

    rational_arith_reduce dut (.*);

    task automatic send(input logic [REQ_W-1:0] op,
                        input logic [W-1:0] na, da, nb, db);
        while (!calm && $urandom_range(99) < 27) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= IN_W'({db, nb, da, na});
        do @(posedge clk); while (!s_tready);
        sb.note_request(op, na, da, nb, db);
    endtask

    function automatic logic [W-1:0] rnd_operand();
        case ($urandom_range(9))
            0: return $urandom_range(3) == 0 ? '0 : {1'b1, {(W-1){1'b0}}};
            1: return {1'b0, {(W-1){1'b1}}};
            2: return W'($urandom_range(5)) - W'(2);
            3, 4: return W'($urandom_range(24)) - W'(12);
            default: return W'($urandom);
        endcase
    endfunction

    always @(posedge clk) begin
        if (m_tvalid && m_tready)
            sb.check_result(frac_t'({m_tdata[NUM_OUT_W-1:0],
                                     m_tdata[NUM_OUT_W+DEN_OUT_W-1:NUM_OUT_W], m_tuser}));
        m_tready <= !hold_off && (calm || $urandom_range(99) >= 27);
    end

    initial begin
        logic [W-1:0] mx, mn;
        mx = {1'b0, {(W-1){1'b1}}};
        mn = {1'b1, {(W-1){1'b0}}};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int op = 0; op < 4; op++) begin
            send(REQ_W'(op), W'(1), W'(2), W'(1), W'(3));
            send(REQ_W'(op), mx, mx, mn, mn);
            send(REQ_W'(op), mn, mn, mn, mn);
            send(REQ_W'(op), W'(0), W'(5), W'(3), W'(-4));
        end
        send(OP_ADD, W'(3), W'(0), W'(1), W'(2));
        send(OP_MUL, W'(3), W'(2), W'(1), W'(0));
        send(OP_DIV, W'(3), W'(2), W'(0), W'(7));
        send(OP_SUB, W'(0), W'(-3), W'(0), W'(7));
        send(OP_DIV, W'(-6), W'(4), W'(3), W'(-2));
        send(OP_SUB, W'(1), W'(2), W'(1), W'(2));
        hold_off = 1'b1;
        fork
            begin
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 300; i++)
                send(REQ_W'($urandom_range(3)), rnd_operand(), rnd_operand(),
                     rnd_operand(), rnd_operand());
        join
        calm = 1'b1;
        for (int i = 0; i < 300; i++)
            send(REQ_W'($urandom_range(3)), rnd_operand(), rnd_operand(),
                 rnd_operand(), rnd_operand());
        calm = 1'b0;
        for (int i = 0; i < 1130; i++)
            send(REQ_W'($urandom_range(3)), rnd_operand(), rnd_operand(),
                 rnd_operand(), rnd_operand());
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (LAT + 20) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_top NOT OK");
        $finish;
    end
endmodule

// ===== files.f =====
src/rar_pkg.sv
src/rar_front.sv
src/rar_gcd_stage.sv
src/rar_div_stage.sv
src/rational_arith_reduce.sv
verif/tb_top.sv
